// ===== hdl/rlfe_pkg.sv =====
// shared types and constants of the rgb led frame encoder
package rlfe_pkg;

  localparam int MaxLeds      = 256;
  localparam int NumLedsW     = 9;
  localparam int ColourW      = 8;
  localparam int PctW         = 7;
  localparam int BrightW      = 5;
  localparam int ProdW        = ColourW + PctW;
  localparam int CntW         = 6;
  localparam int StartBytes   = 4;

  localparam logic [PctW-1:0]    PctMax     = 7'd100;
  localparam logic [2:0]         HdrMark    = 3'b111;
  localparam logic [ColourW-1:0] StartByte  = 8'h00;
  localparam logic [ColourW-1:0] EndByte    = 8'hFF;
  localparam logic [12:0]        Div100Mul  = 13'd5243;
  localparam int                 Div100Shft = 19;
  localparam logic [9:0]         EndRound   = 10'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_HDR,
    ST_BLUE,
    ST_GREEN,
    ST_RED,
    ST_END
  } seq_state_e;

  typedef struct packed {
    logic               load;
    logic               valid;
    logic [BrightW-1:0] bright;
    logic [ProdW-1:0]   prod_b;
    logic [ProdW-1:0]   prod_g;
    logic [ProdW-1:0]   prod_r;
  } slot_t;

  typedef struct packed {
    logic                release_slot;
    logic                busy;
    logic [NumLedsW-1:0] pos;
  } seq_stat_t;

endpackage

// ===== hdl/rlfe_if.sv =====
// led record and output byte channel interfaces
interface rlfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [6:0] intensity;
  logic [4:0] brightness;

  modport source (output valid, red, green, blue, intensity, brightness, input ready);
  modport sink (input valid, red, green, blue, intensity, brightness, output ready);
endinterface

interface rlfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_item;
  logic       last_of_frame;

  modport source (output valid, data_byte, last_of_item, last_of_frame, input ready);
  modport sink (input valid, data_byte, last_of_item, last_of_frame, output ready);
endinterface

// ===== hdl/rlfe_capture.sv =====
// input slot: takes one led record and registers the colour-times-intensity products, not yet divided by 100
module rlfe_capture (
  input  logic                clk_i,
  input  logic                rst_ni,
  rlfe_in_if.sink             in_i,
  input  rlfe_pkg::seq_stat_t stat_i,
  output rlfe_pkg::slot_t     slot_o
);
  import rlfe_pkg::*;

  logic               valid_q, valid_d;
  logic               accept;
  logic [PctW-1:0]    pct;
  logic [BrightW-1:0] bright_q;
  logic [ProdW-1:0]   prod_b_q, prod_g_q, prod_r_q;

  assign in_i.ready = !valid_q || stat_i.release_slot;
  assign accept     = in_i.valid && in_i.ready;
  assign pct        = (in_i.intensity > PctMax) ? PctMax : in_i.intensity;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (stat_i.release_slot) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bright_q <= in_i.brightness;
      prod_b_q <= ProdW'(in_i.blue * pct);
      prod_g_q <= ProdW'(in_i.green * pct);
      prod_r_q <= ProdW'(in_i.red * pct);
    end
  end

  assign slot_o.load   = accept;
  assign slot_o.valid  = valid_q;
  assign slot_o.bright = bright_q;
  assign slot_o.prod_b = prod_b_q;
  assign slot_o.prod_g = prod_g_q;
  assign slot_o.prod_r = prod_r_q;

endmodule

// ===== hdl/rlfe_seq.sv =====
// byte sequencer: frame position, byte selection and output byte register
module rlfe_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rlfe_pkg::NumLedsW-1:0] num_leds_i,
  input  rlfe_pkg::slot_t               slot_i,
  output rlfe_pkg::seq_stat_t           stat_o,
  rlfe_out_if.source                    out_o
);
  import rlfe_pkg::*;

  seq_state_e          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [NumLedsW-1:0] pos_q, pos_d, pos_inc, frame_n;
  logic [9:0]          end_sum;
  logic [CntW-1:0]     end_cnt;
  logic                frame_done;
  logic                emit, item_done;
  logic [ColourW-1:0]  byte_d;
  logic                last_item_d, last_frame_d;
  logic                out_valid_q;
  logic [ColourW-1:0]  out_byte_q;
  logic                out_item_q, out_frame_q;
  logic [ProdW-1:0]    prod_sel;
  logic [27:0]         quot_full;

  always_comb begin
    if (num_leds_i == '0) begin
      frame_n = NumLedsW'(1);
    end else if (int'(num_leds_i) > MaxLeds) begin
      frame_n = NumLedsW'(MaxLeds);
    end else begin
      frame_n = num_leds_i;
    end
  end

  assign end_sum    = {1'b0, frame_n} + EndRound;
  assign end_cnt    = end_sum[9:4];
  assign pos_inc    = pos_q + NumLedsW'(1);
  assign frame_done = (pos_inc >= frame_n) || (pos_inc == '0);

  // divide by 100 through a reciprocal multiply, exact for products up to 25500
  always_comb begin
    unique case (state_q)
      ST_BLUE:  prod_sel = slot_i.prod_b;
      ST_GREEN: prod_sel = slot_i.prod_g;
      default:  prod_sel = slot_i.prod_r;
    endcase
  end
  assign quot_full = 28'(prod_sel * Div100Mul);

  assign emit = (state_q != ST_IDLE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    byte_d       = StartByte;
    last_item_d  = 1'b0;
    last_frame_d = 1'b0;
    item_done    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
      end
      ST_START: begin
        byte_d = StartByte;
        if (emit) begin
          if (cnt_q == CntW'(StartBytes - 1)) begin
            cnt_d   = '0;
            state_d = ST_HDR;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
      ST_HDR: begin
        byte_d = {HdrMark, slot_i.bright};
        if (emit) state_d = ST_BLUE;
      end
      ST_BLUE: begin
        byte_d = quot_full[Div100Shft +: ColourW];
        if (emit) state_d = ST_GREEN;
      end
      ST_GREEN: begin
        byte_d = quot_full[Div100Shft +: ColourW];
        if (emit) state_d = ST_RED;
      end
      ST_RED: begin
        byte_d      = quot_full[Div100Shft +: ColourW];
        last_item_d = !frame_done;
        if (emit) begin
          if (frame_done) begin
            pos_d   = '0;
            cnt_d   = '0;
            state_d = ST_END;
          end else begin
            pos_d     = pos_inc;
            item_done = 1'b1;
          end
        end
      end
      ST_END: begin
        byte_d       = EndByte;
        last_item_d  = (cnt_q + CntW'(1) == end_cnt);
        last_frame_d = last_item_d;
        if (emit) begin
          if (last_item_d) begin
            cnt_d     = '0;
            item_done = 1'b1;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (state_q == ST_IDLE || item_done) begin
      if (slot_i.load) begin
        state_d = (pos_d == '0) ? ST_START : ST_HDR;
      end else begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q  <= byte_d;
      out_item_q  <= last_item_d;
      out_frame_q <= last_frame_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.data_byte     = out_byte_q;
  assign out_o.last_of_item  = out_item_q;
  assign out_o.last_of_frame = out_frame_q;

  assign stat_o.release_slot = item_done;
  assign stat_o.busy         = (state_q != ST_IDLE);
  assign stat_o.pos          = pos_q;

endmodule

// ===== hdl/rgb_led_frame_encoder.sv =====
// top level of the rgb led frame encoder
// Takes one LED record per transfer and produces the serial byte stream of an
// APA102-style chain, one byte per output transfer. A record normally takes 4
// bytes (header, blue, green, red); the first record of a frame adds 4 zero
// start bytes and the record that completes a frame adds ceil(n/16) 0xFF end
// bytes, n being num_leds clamped to 1..256. The output byte register moves
// one byte per cycle unless the output stalls, which sets the rate. The next
// record is taken into the input slot as the last byte of the current one is
// registered, so records stream without gaps. num_leds is written through
// cfg_we_i/cfg_wdata_i and resets to 1; write it only while the block is idle.
module rgb_led_frame_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rlfe_pkg::NumLedsW-1:0] cfg_wdata_i,
  rlfe_in_if.sink                       in_i,
  rlfe_out_if.source                    out_o
);
  import rlfe_pkg::*;

  logic [NumLedsW-1:0] num_leds_q;
  slot_t               slot;
  seq_stat_t           stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_leds_q <= NumLedsW'(1);
    end else if (cfg_we_i) begin
      num_leds_q <= cfg_wdata_i;
    end
  end

  rlfe_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .stat_i (stat),
    .slot_o (slot)
  );

  rlfe_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .num_leds_i (num_leds_q),
    .slot_i     (slot),
    .stat_o     (stat),
    .out_o      (out_o)
  );

  a_frame_end_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last_of_frame |-> out_o.last_of_item && out_o.data_byte == EndByte)
    else $error("frame end byte malformed");

  a_slot_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot.valid == stat.busy)
    else $error("input slot and sequencer out of step");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> int'(stat.pos) < MaxLeds)
    else $error("led position beyond frame");

endmodule

// ===== sim/tb_rgb_led_frame_encoder.sv =====
// testbench of the rgb led frame encoder: directed table then random frames, bytes checked in order
module tb_rgb_led_frame_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import rlfe_pkg::*;

  localparam int IdlePct      = 11;
  localparam int RandItems    = 414;
  localparam int SettleCycles = 4;
  localparam int StallLimit   = 2000;
  localparam int NumRows      = 22;

  typedef enum logic {
    ROW_CFG,
    ROW_LED
  } row_kind_e;

  typedef struct packed {
    logic [ColourW-1:0] red;
    logic [ColourW-1:0] green;
    logic [ColourW-1:0] blue;
    logic [PctW-1:0]    intensity;
    logic [BrightW-1:0] brightness;
  } led_rec_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_item;
    logic       last_of_frame;
  } led_byte_t;

  typedef led_byte_t byte_q_t[$];

  // fixed bytes are right-aligned, first byte on the line in the top used byte
  typedef struct packed {
    row_kind_e           kind;
    logic [NumLedsW-1:0] leds;
    led_rec_t            rec;
    logic [3:0]          n_fixed;
    logic [95:0]         fixed;
    logic                fixed_eof;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [NumLedsW-1:0] cfg_wdata;
  bit                  steady = 1'b0;
  int                  cur_row = -1;

  logic [NumLedsW-1:0] num_leds_m = NumLedsW'(1);
  logic [NumLedsW-1:0] led_pos_m  = '0;
  led_byte_t           bytes_due[$];

  int mismatches = 0;
  int leds_taken = 0;
  int bytes_seen = 0;
  int frames_seen = 0;
  int writes_done = 0;
  int rand_sent = 0;
  int quiet = 0;

  stim_row_t directed_rows [NumRows] = '{
    '{ROW_LED, 9'd0, '{8'd255, 8'd255, 8'd255, 7'd100, 5'd31}, 4'd9,
      96'h00000000_FFFFFFFF_FF, 1'b1},
    '{ROW_LED, 9'd0, '{8'd0, 8'd0, 8'd0, 7'd0, 5'd0}, 4'd9,
      96'h00000000_E0000000_FF, 1'b1},
    '{ROW_LED, 9'd0, '{8'd255, 8'd255, 8'd255, 7'd127, 5'd31}, 4'd9,
      96'h00000000_FFFFFFFF_FF, 1'b1},
    '{ROW_LED, 9'd0, '{8'd200, 8'd100, 8'd50, 7'd101, 5'd10}, 4'd0, 96'h0, 1'b0},
    '{ROW_LED, 9'd0, '{8'd255, 8'd128, 8'd1, 7'd0, 5'd21}, 4'd9,
      96'h00000000_F5000000_FF, 1'b1},
    '{ROW_CFG, 9'd0, '0, 4'd0, 96'h0, 1'b0},
    '{ROW_LED, 9'd0, '{8'd255, 8'd255, 8'd255, 7'd1, 5'd0}, 4'd0, 96'h0, 1'b0},
    '{ROW_LED, 9'd0, '{8'd99, 8'd77, 8'd33, 7'd99, 5'd5}, 4'd0, 96'h0, 1'b0},
    '{ROW_CFG, 9'd511, '0, 4'd0, 96'h0, 1'b0},
    '{ROW_LED, 9'd0, '{8'd12, 8'd34, 8'd56, 7'd50, 5'd1}, 4'd0, 96'h0, 1'b0},
    '{ROW_LED, 9'd0, '{8'd255, 8'd0, 8'd255, 7'd100, 5'd31}, 4'd4, 96'hFFFF00FF, 1'b0},
    '{ROW_LED, 9'd0, '{8'd1, 8'd2, 8'd3, 7'd100, 5'd2}, 4'd4, 96'hE2030201, 1'b0},
    '{ROW_CFG, 9'd3, '0, 4'd0, 96'h0, 1'b0},
    '{ROW_LED, 9'd0, '{8'd9, 8'd9, 8'd9, 7'd33, 5'd3}, 4'd0, 96'h0, 1'b0},
    '{ROW_CFG, 9'd256, '0, 4'd0, 96'h0, 1'b0},
    '{ROW_LED, 9'd0, '{8'd128, 8'd64, 8'd32, 7'd75, 5'd16}, 4'd0, 96'h0, 1'b0},
    '{ROW_LED, 9'd0, '{8'd250, 8'd5, 8'd125, 7'd100, 5'd8}, 4'd0, 96'h0, 1'b0},
    '{ROW_CFG, 9'd1, '0, 4'd0, 96'h0, 1'b0},
    '{ROW_LED, 9'd0, '{8'd77, 8'd88, 8'd99, 7'd100, 5'd30}, 4'd0, 96'h0, 1'b0},
    '{ROW_CFG, 9'd2, '0, 4'd0, 96'h0, 1'b0},
    '{ROW_LED, 9'd0, '{8'd1, 8'd1, 8'd1, 7'd100, 5'd0}, 4'd8,
      96'h00000000_E0010101, 1'b0},
    '{ROW_LED, 9'd0, '{8'd254, 8'd254, 8'd254, 7'd100, 5'd31}, 4'd5,
      96'hFF_FEFEFE_FF, 1'b1}
  };

  rlfe_in_if  led_if ();
  rlfe_out_if byte_if ();

  rgb_led_frame_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (led_if),
    .out_o       (byte_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_leds(input logic [NumLedsW-1:0] v);
    if (v == '0) return 1;
    if (v > MaxLeds) return MaxLeds;
    return 32'(v);
  endfunction

  function automatic logic [7:0] scale_colour(input logic [7:0] c, input logic [PctW-1:0] pct);
    return 8'((int'(c) * int'(pct)) / 100);
  endfunction

  // bytes on the line for one led record, advances the frame position
  function automatic void encode_led(input led_rec_t r, output byte_q_t bytes_o);
    int unsigned     n;
    int unsigned     ends;
    logic [PctW-1:0] pct;
    bytes_o = {};
    n = clamp_leds(num_leds_m);
    pct = (r.intensity > PctMax) ? PctMax : r.intensity;
    if (led_pos_m == '0) begin
      repeat (StartBytes) bytes_o.push_back('{StartByte, 1'b0, 1'b0});
    end
    bytes_o.push_back('{{HdrMark, r.brightness}, 1'b0, 1'b0});
    bytes_o.push_back('{scale_colour(r.blue, pct), 1'b0, 1'b0});
    bytes_o.push_back('{scale_colour(r.green, pct), 1'b0, 1'b0});
    bytes_o.push_back('{scale_colour(r.red, pct), 1'b0, 1'b0});
    led_pos_m = led_pos_m + 1'b1;
    if (led_pos_m >= n || led_pos_m == '0) begin
      ends = (n + 15) / 16;
      for (int unsigned k = 1; k <= ends; k++) begin
        bytes_o.push_back('{EndByte, 1'b0, k == ends});
      end
      led_pos_m = '0;
    end
    bytes_o[bytes_o.size() - 1].last_of_item = 1'b1;
  endfunction

  function automatic logic [7:0] draw_colour();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic led_rec_t draw_led();
    led_rec_t r;
    r.red = draw_colour();
    r.green = draw_colour();
    r.blue = draw_colour();
    r.intensity = ($urandom_range(7) == 0) ? PctMax : PctW'($urandom_range(127));
    r.brightness = BrightW'($urandom);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got_v, input int want_v);
    mismatches++;
    $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got_v, want_v);
  endtask

  task automatic send_led(input led_rec_t r, input int row);
    while (!steady && $urandom_range(99) < IdlePct) begin
      led_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    led_if.valid <= 1'b1;
    led_if.red <= r.red;
    led_if.green <= r.green;
    led_if.blue <= r.blue;
    led_if.intensity <= r.intensity;
    led_if.brightness <= r.brightness;
    cur_row <= row;
    do @(posedge clk_i); while (!led_if.ready);
  endtask

  task automatic drain();
    led_if.valid <= 1'b0;
    @(posedge clk_i);
    while (bytes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_leds(input logic [NumLedsW-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    writes_done++;
  endtask

  always @(posedge clk_i) begin
    byte_if.ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin : track_bytes
    byte_q_t   fresh;
    led_byte_t got;
    led_byte_t want;
    stim_row_t row;
    led_rec_t  rec;
    if (rst_ni) begin
      if (cfg_we) begin
        num_leds_m = cfg_wdata;
      end
      if (led_if.valid && led_if.ready) begin
        rec = '{led_if.red, led_if.green, led_if.blue, led_if.intensity, led_if.brightness};
        encode_led(rec, fresh);
        if (cur_row >= 0 && directed_rows[cur_row].n_fixed != 0) begin
          row = directed_rows[cur_row];
          fresh = {};
          for (int k = 0; k < int'(row.n_fixed); k++) begin
            fresh.push_back('{row.fixed[(int'(row.n_fixed) - 1 - k) * 8 +: 8],
                              k == int'(row.n_fixed) - 1,
                              row.fixed_eof && k == int'(row.n_fixed) - 1});
          end
        end
        foreach (fresh[k]) bytes_due.push_back(fresh[k]);
        leds_taken++;
      end
      if (byte_if.valid && byte_if.ready) begin
        got = '{byte_if.data_byte, byte_if.last_of_item, byte_if.last_of_frame};
        bytes_seen++;
        if (got.last_of_frame) frames_seen++;
        if (bytes_due.size() == 0) begin
          flag_mismatch("byte with nothing due", got.data_byte, 0);
        end else begin
          want = bytes_due.pop_front();
          if (got.data_byte !== want.data_byte)
            flag_mismatch("data_byte", got.data_byte, want.data_byte);
          if (got.last_of_item !== want.last_of_item)
            flag_mismatch("last_of_item", got.last_of_item, want.last_of_item);
          if (got.last_of_frame !== want.last_of_frame)
            flag_mismatch("last_of_frame", got.last_of_frame, want.last_of_frame);
        end
      end
    end
  end

  // cycles with no transfer and no register write
  always @(posedge clk_i) begin
    if (!rst_ni || (led_if.valid && led_if.ready) || (byte_if.valid && byte_if.ready) || cfg_we)
    begin
      quiet = 0;
    end else if (quiet >= StallLimit) begin
      $display("%0t ns: no transfer for %0d cycles, giving up", $time, StallLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet++;
    end
  end

  initial begin
    logic [NumLedsW-1:0] leds;
    int unsigned         eff;
    int unsigned         count;
    int unsigned         pos;
    int                  phase;
    bit                  big;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    led_if.valid = 1'b0;
    led_if.red = '0;
    led_if.green = '0;
    led_if.blue = '0;
    led_if.intensity = '0;
    led_if.brightness = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_leds(directed_rows[i].leds);
      end else begin
        send_led(directed_rows[i].rec, i);
      end
    end

    phase = 0;
    while (rand_sent < RandItems) begin
      big = (phase == 0);
      if (big) begin
        leds = $urandom_range(1) ? NumLedsW'(MaxLeds) : NumLedsW'($urandom_range(511, MaxLeds + 1));
      end else begin
        case ($urandom_range(9))
          0: leds = '0;
          1: leds = NumLedsW'($urandom_range(511, MaxLeds + 1));
          default: leds = NumLedsW'($urandom_range(40, 1));
        endcase
      end
      write_leds(leds);
      eff = clamp_leds(leds);
      if (big) begin
        count = eff;
      end else if (eff > 64) begin
        count = $urandom_range(40, 1);
      end else begin
        count = eff * $urandom_range(3, 1) + (($urandom_range(3) == 0) ? $urandom_range(eff, 1) : 0);
      end
      // long stretch with both sides flat out in the middle of the full frame
      for (int unsigned k = 0; k < count && rand_sent < RandItems; k++) begin
        steady <= big && k >= eff / 3 && k < 2 * eff / 3;
        send_led(draw_led(), -1);
        rand_sent++;
      end
      steady <= 1'b0;
      // shortened frame: lower the length to at most the leds already sent
      if (!big && (eff > 64 || $urandom_range(2) == 0)) begin
        drain();
        pos = led_pos_m;
        if (pos != 0) begin
          write_leds(NumLedsW'($urandom_range(pos)));
          repeat ($urandom_range(3, 1)) begin
            send_led(draw_led(), -1);
            rand_sent++;
          end
        end
      end
      phase++;
    end

    drain();
    if (bytes_due.size() != 0) flag_mismatch("bytes never sent", 0, bytes_due.size());
    $display("run covered %0d led records (%0d from the table) over %0d random phases",
             leds_taken, NumRows - 6, phase);
    $display("%0d bytes checked, %0d frames closed, %0d length writes incl. 0, 1, 256, 511",
             bytes_seen, frames_seen, writes_done);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
